### rtl/core/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg: shared types for the midpoint line rasterizer
// Holds the action codes and the flag group that travels with each command
// from the front end, through the command queue, to the stepping back end.
// ----------------------------------------------------------------------------
package mlr_pkg;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } action_t;

    typedef struct packed {
        action_t action;
        logic    x_is_major;
        logic    x_dir_neg;
        logic    y_dir_neg;
    } line_flags_t;

    localparam int FLAGS_BITS = $bits(line_flags_t);

endpackage

### rtl/core/mlr_channels.sv
// ----------------------------------------------------------------------------
// mlr_channels: valid/ready channels of the midpoint line rasterizer
// mlr_line_if carries load and step items in; mlr_pixel_if carries pixels out.
// ----------------------------------------------------------------------------
interface mlr_line_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_pixel_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

### rtl/core/mlr_front.sv
// ----------------------------------------------------------------------------
// mlr_front: item intake and line setup
// Classifies each item and, for a load, works out the axis distances, the
// step directions and the major axis before the command enters the queue.
// ----------------------------------------------------------------------------
module mlr_front #(
    parameter int COORD_BITS = 12
) (
    mlr_line_if.sink                  line_in,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output mlr_pkg::line_flags_t      cmd_flags,
    output logic [COORD_BITS-1:0]     cmd_x_start,
    output logic [COORD_BITS-1:0]     cmd_y_start,
    output logic [COORD_BITS-1:0]     cmd_major,
    output logic [COORD_BITS-1:0]     cmd_minor
);
    import mlr_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] adx_full;
    logic        [COORD_BITS:0] ady_full;
    logic [COORD_BITS-1:0]      adx;
    logic [COORD_BITS-1:0]      ady;
    logic                       x_major;

    // One extra bit holds the full difference of two signed coordinates.
    assign dx = $signed({line_in.x_end[COORD_BITS-1], line_in.x_end})
              - $signed({line_in.x_start[COORD_BITS-1], line_in.x_start});
    assign dy = $signed({line_in.y_end[COORD_BITS-1], line_in.y_end})
              - $signed({line_in.y_start[COORD_BITS-1], line_in.y_start});

    assign adx_full = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    assign ady_full = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

    // A distance never exceeds the span of one coordinate, so the top bit drops.
    assign adx = adx_full[COORD_BITS-1:0];
    assign ady = ady_full[COORD_BITS-1:0];

    assign x_major = (adx >= ady);

    always_comb
    begin
        cmd_flags.action     = action_t'(line_in.action);
        cmd_flags.x_is_major = x_major;
        cmd_flags.x_dir_neg  = dx[COORD_BITS];
        cmd_flags.y_dir_neg  = dy[COORD_BITS];
    end

    assign cmd_valid     = line_in.valid;
    assign line_in.ready = cmd_ready;
    assign cmd_x_start   = line_in.x_start;
    assign cmd_y_start   = line_in.y_start;
    assign cmd_major     = x_major ? adx : ady;
    assign cmd_minor     = x_major ? ady : adx;

endmodule

### rtl/core/mlr_queue.sv
// ----------------------------------------------------------------------------
// mlr_queue: command queue between front end and back end
// A small first-in first-out buffer so that intake and stepping stall apart.
// ----------------------------------------------------------------------------
module mlr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    // DEPTH must be a power of two so that the pointers wrap on their own; the block does not enforce it.
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/mlr_back.sv
// ----------------------------------------------------------------------------
// mlr_back: line stepper and pixel output register
// Keeps the current pixel and the doubled decision variable, takes one queue
// command each cycle (a step waits out a pixel stall), registers the emitted pixel.
// ----------------------------------------------------------------------------
module mlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_pop,
    input  mlr_pkg::line_flags_t      cmd_flags,
    input  logic [COORD_BITS-1:0]     cmd_x_start,
    input  logic [COORD_BITS-1:0]     cmd_y_start,
    input  logic [COORD_BITS-1:0]     cmd_major,
    input  logic [COORD_BITS-1:0]     cmd_minor,
    mlr_pixel_if.source               pixel_out
);
    import mlr_pkg::*;

    // The decision variable stays within plus or minus twice the major distance.
    localparam int DW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg;
    logic [COORD_BITS-1:0] cur_y_reg;
    logic [DW-1:0]         decision_reg;
    logic [DW-1:0]         inc_straight_reg;
    logic [DW-1:0]         inc_diag_reg;
    logic [COORD_BITS-1:0] steps_left_reg;
    logic                  x_is_major_reg;
    logic                  x_dir_neg_reg;
    logic                  y_dir_neg_reg;
    logic                  line_active_reg;
    logic                  first_pending_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    logic                  slot_free;
    logic                  is_load;
    logic                  do_load;
    logic                  do_emit;
    logic                  minor_step;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic [COORD_BITS-1:0] moved_x;
    logic [COORD_BITS-1:0] moved_y;
    logic [COORD_BITS-1:0] emit_x;
    logic [COORD_BITS-1:0] emit_y;
    logic                  emit_last;
    logic [DW-1:0]         minor_x2;
    logic [DW-1:0]         major_x2;
    logic [DW-1:0]         major_ext;

    assign slot_free = !out_valid_reg || pixel_out.ready;
    assign is_load   = (cmd_flags.action == ACT_LOAD);

    // A load never produces a pixel, so it leaves the queue even under a stall.
    assign cmd_pop = cmd_valid && (is_load || slot_free);
    assign do_load = cmd_pop && is_load;
    assign do_emit = cmd_pop && !is_load && line_active_reg;

    assign minor_step = !decision_reg[DW-1];
    assign step_x     = x_dir_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign step_y     = y_dir_neg_reg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

    always_comb
    begin
        moved_x = cur_x_reg;
        moved_y = cur_y_reg;
        if (x_is_major_reg || minor_step)
        begin
            moved_x = cur_x_reg + step_x;
        end
        if (!x_is_major_reg || minor_step)
        begin
            moved_y = cur_y_reg + step_y;
        end
    end

    // The start pixel goes out unmoved; every later item takes one major step.
    assign emit_x    = first_pending_reg ? cur_x_reg : moved_x;
    assign emit_y    = first_pending_reg ? cur_y_reg : moved_y;
    assign emit_last = first_pending_reg ? (steps_left_reg == '0)
                                         : (steps_left_reg == COORD_BITS'(1));

    assign minor_x2  = {1'b0, cmd_minor, 1'b0};
    assign major_x2  = {1'b0, cmd_major, 1'b0};
    assign major_ext = {2'b00, cmd_major};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg   <= 1'b0;
            first_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                line_active_reg   <= 1'b1;
                first_pending_reg <= 1'b1;
            end
            else if (do_emit)
            begin
                first_pending_reg <= 1'b0;
                if (emit_last)
                begin
                    line_active_reg <= 1'b0;
                end
            end

            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            cur_x_reg        <= cmd_x_start;
            cur_y_reg        <= cmd_y_start;
            decision_reg     <= minor_x2 - major_ext;
            inc_straight_reg <= minor_x2;
            inc_diag_reg     <= minor_x2 - major_x2;
            steps_left_reg   <= cmd_major;
            x_is_major_reg   <= cmd_flags.x_is_major;
            x_dir_neg_reg    <= cmd_flags.x_dir_neg;
            y_dir_neg_reg    <= cmd_flags.y_dir_neg;
        end
        else if (do_emit && !first_pending_reg)
        begin
            cur_x_reg      <= moved_x;
            cur_y_reg      <= moved_y;
            decision_reg   <= decision_reg + (minor_step ? inc_diag_reg : inc_straight_reg);
            steps_left_reg <= steps_left_reg - COORD_BITS'(1);
        end

        if (do_emit)
        begin
            out_x_reg    <= emit_x;
            out_y_reg    <= emit_y;
            out_last_reg <= emit_last;
        end
    end

    assign pixel_out.valid   = out_valid_reg;
    assign pixel_out.pixel_x = out_x_reg;
    assign pixel_out.pixel_y = out_y_reg;
    assign pixel_out.last    = out_last_reg;

endmodule

### rtl/core/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top: midpoint line rasterizer
// Turns a pair of endpoints into the run of pixels between them.
// ----------------------------------------------------------------------------
// Usage:
//   line_in carries items. An item with action 0 loads a new line from
//   x_start, y_start, x_end and y_end and replaces any line in progress; it
//   produces no pixel. An item with action 1 asks for the next pixel.
//   pixel_out carries one pixel per step item while a line is active, from
//   the start pixel through the end pixel; last marks the end pixel. Step
//   items with no active line produce nothing.
//   A step item accepted on line_in goes into the command queue and, once
//   popped, into the pixel register that drives pixel_out. Items are
//   accepted one per cycle while the queue has room; each later step is
//   one decision-variable add and a major-axis step (minor too when due).
//   A two-entry command queue sits between intake and stepping. When the
//   receiver stalls, the pixel register holds, the queue fills to its two
//   entries and line_in drops ready until a pixel is taken. Reset empties
//   the queue, drops any line and clears the pixel output valid.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    mlr_line_if.sink     line_in,
    mlr_pixel_if.source  pixel_out
);
    import mlr_pkg::*;

    localparam int CMD_W = FLAGS_BITS + 4 * COORD_BITS;

    logic                  f_valid;
    logic                  f_ready;
    line_flags_t           f_flags;
    logic [COORD_BITS-1:0] f_x_start;
    logic [COORD_BITS-1:0] f_y_start;
    logic [COORD_BITS-1:0] f_major;
    logic [COORD_BITS-1:0] f_minor;

    logic                  q_valid;
    logic                  q_pop;
    logic [CMD_W-1:0]      q_data;
    line_flags_t           q_flags;
    logic [COORD_BITS-1:0] q_x_start;
    logic [COORD_BITS-1:0] q_y_start;
    logic [COORD_BITS-1:0] q_major;
    logic [COORD_BITS-1:0] q_minor;

    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .line_in     (line_in),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd_flags   (f_flags),
        .cmd_x_start (f_x_start),
        .cmd_y_start (f_y_start),
        .cmd_major   (f_major),
        .cmd_minor   (f_minor)
    );

    mlr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_flags, f_x_start, f_y_start, f_major, f_minor}),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    assign {q_flags, q_x_start, q_y_start, q_major, q_minor} = q_data;

    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_pop     (q_pop),
        .cmd_flags   (q_flags),
        .cmd_x_start (q_x_start),
        .cmd_y_start (q_y_start),
        .cmd_major   (q_major),
        .cmd_minor   (q_minor),
        .pixel_out   (pixel_out)
    );

endmodule

### rtl/core/mlr_checker.sv
// ----------------------------------------------------------------------------
// mlr_checker: port-level checks for the midpoint line rasterizer
// Watches the top-level channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mlr_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  in_action,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] out_x,
    input logic [COORD_BITS-1:0] out_y,
    input logic                  out_last
);
    import mlr_pkg::*;

    logic seen_load_reg;

    // Set once any load item has been accepted since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_load_reg <= 1'b0;
        end
        else if (in_valid && in_ready && (action_t'(in_action) == ACT_LOAD))
        begin
            seen_load_reg <= 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("pixel output valid during reset");

    a_pixel_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_load_reg)
        else $error("pixel emitted before any line was loaded");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel output withdrawn while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_last))
        else $error("pixel payload changed while stalled");

endmodule

bind midpoint_line_rasterizer_top mlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_mlr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (line_in.valid),
    .in_ready  (line_in.ready),
    .in_action (line_in.action),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .out_x     (pixel_out.pixel_x),
    .out_y     (pixel_out.pixel_y),
    .out_last  (pixel_out.last)
);
